>>> rtl/sfa_pkg.sv
package sfa_pkg;

  // Longest spectrum the multiplexer sequence supports
  localparam int unsigned SEQ_LENGTH = 18;

  // Frame layout
  localparam logic [6:0] WORD_MAP_MASK = 7'h7e;
  localparam int unsigned HIGH_BYTE_SHIFT = 8;

  // Spectrum lengths per multiplexer mode
  localparam logic [1:0] SMUX_SIX      = 2'd0;
  localparam logic [1:0] SMUX_TWELVE   = 2'd1;
  localparam logic [4:0] LEN_SIX       = 5'd6;
  localparam logic [4:0] LEN_TWELVE    = (SEQ_LENGTH < 12) ? 5'(SEQ_LENGTH) : 5'd12;
  localparam logic [4:0] LEN_EIGHTEEN  = 5'(SEQ_LENGTH);

  // Register indexes (byte address 4*index)
  localparam logic [1:0] REG_FIFO_MAP    = 2'd0;
  localparam logic [1:0] REG_SMUX_MODE   = 2'd1;
  localparam logic [1:0] REG_HIGH_TARGET = 2'd2;
  localparam logic [1:0] REG_LOW_TARGET  = 2'd3;

  // Register reset values
  localparam logic [6:0]  FIFO_MAP_RST    = 7'h7f;
  localparam logic [1:0]  SMUX_MODE_RST   = 2'd2;
  localparam logic [15:0] HIGH_TARGET_RST = 16'hffff;
  localparam logic [15:0] LOW_TARGET_RST  = 16'h0000;

  // Input actions
  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_RESYNC = 1'b1;

  // Exposure verdicts
  localparam logic [1:0] VERDICT_HOLD     = 2'd0;
  localparam logic [1:0] VERDICT_DECREASE = 2'd1;
  localparam logic [1:0] VERDICT_INCREASE = 2'd2;

  // Channel codes
  localparam logic [3:0] CH_F1  = 4'd0;
  localparam logic [3:0] CH_F2  = 4'd1;
  localparam logic [3:0] CH_Z   = 4'd2;
  localparam logic [3:0] CH_F3  = 4'd3;
  localparam logic [3:0] CH_F4  = 4'd4;
  localparam logic [3:0] CH_Y   = 4'd5;
  localparam logic [3:0] CH_F5  = 4'd6;
  localparam logic [3:0] CH_FXL = 4'd7;
  localparam logic [3:0] CH_F6  = 4'd8;
  localparam logic [3:0] CH_F7  = 4'd9;
  localparam logic [3:0] CH_F8  = 4'd10;
  localparam logic [3:0] CH_NIR = 4'd11;
  localparam logic [3:0] CH_VIS = 4'd12;
  localparam logic [3:0] CH_FD  = 4'd13;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  channel_code;
    logic [4:0]  slot_index;
    logic [15:0] sample_value;
    logic        spectrum_last;
    logic [15:0] peak_value;
    logic [3:0]  peak_channel;
    logic [1:0]  exposure_verdict;
  } out_t;

  // Spectrum progress carried between words
  typedef struct packed {
    logic [4:0]  pos;
    logic [15:0] peak;
    logic [3:0]  peak_ch;
  } spec_state_t;

  // Multiplexer sequence: three groups of six
  function automatic logic [3:0] seq_code(input logic [4:0] idx);
    logic [3:0] code;
    unique case (idx)
      5'd0:    code = CH_Z;
      5'd1:    code = CH_Y;
      5'd2:    code = CH_FXL;
      5'd3:    code = CH_NIR;
      5'd4:    code = CH_VIS;
      5'd5:    code = CH_FD;
      5'd6:    code = CH_F2;
      5'd7:    code = CH_F3;
      5'd8:    code = CH_F4;
      5'd9:    code = CH_F6;
      5'd10:   code = CH_VIS;
      5'd11:   code = CH_FD;
      5'd12:   code = CH_F1;
      5'd13:   code = CH_F7;
      5'd14:   code = CH_F8;
      5'd15:   code = CH_F5;
      5'd16:   code = CH_VIS;
      5'd17:   code = CH_FD;
      default: code = CH_F1;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/sfa_peak_unit.sv
// Tags one assembled word, tracks the spectrum maximum and forms the verdict
module sfa_peak_unit (
  input  logic [1:0]          smux_mode,
  input  logic [15:0]         high_target,
  input  logic [15:0]         low_target,
  input  logic [15:0]         word,
  input  sfa_pkg::spec_state_t cur,
  output sfa_pkg::spec_state_t nxt,
  output sfa_pkg::out_t       result,
  output logic                last
);

  logic [4:0]  len;
  logic        wrap;
  logic [4:0]  pos;
  logic [15:0] base_peak;
  logic [3:0]  base_ch;
  logic [3:0]  code;
  logic [15:0] new_peak;
  logic [3:0]  new_ch;
  logic [1:0]  verdict;

  // Spectrum length from mode; unused mode acts as full length
  always_comb begin
    unique case (smux_mode)
      sfa_pkg::SMUX_SIX:    len = sfa_pkg::LEN_SIX;
      sfa_pkg::SMUX_TWELVE: len = sfa_pkg::LEN_TWELVE;
      default:              len = sfa_pkg::LEN_EIGHTEEN;
    endcase
  end

  // Restart spectrum if a mode change left us past its end
  assign wrap      = (cur.pos >= len);
  assign pos       = wrap ? 5'd0 : cur.pos;
  assign base_peak = wrap ? 16'd0 : cur.peak;
  assign base_ch   = wrap ? 4'd0 : cur.peak_ch;
  assign code      = sfa_pkg::seq_code(pos);

  // Strict compare keeps the earlier channel on ties
  assign new_peak = (word > base_peak) ? word : base_peak;
  assign new_ch   = (word > base_peak) ? code : base_ch;

  assign last = ((pos + 5'd1) >= len);

  always_comb begin
    priority if (new_peak > high_target) begin
      verdict = sfa_pkg::VERDICT_DECREASE;
    end else if (new_peak < low_target) begin
      verdict = sfa_pkg::VERDICT_INCREASE;
    end else begin
      verdict = sfa_pkg::VERDICT_HOLD;
    end
  end

  always_comb begin
    result.channel_code     = code;
    result.slot_index       = pos;
    result.sample_value     = word;
    result.spectrum_last    = last;
    result.peak_value       = last ? new_peak : 16'd0;
    result.peak_channel     = last ? new_ch : 4'd0;
    result.exposure_verdict = last ? verdict : sfa_pkg::VERDICT_HOLD;
    if (last) begin
      nxt.pos     = 5'd0;
      nxt.peak    = 16'd0;
      nxt.peak_ch = 4'd0;
    end else begin
      nxt.pos     = pos + 5'd1;
      nxt.peak    = new_peak;
      nxt.peak_ch = new_ch;
    end
  end

endmodule

>>> rtl/spectral_fifo_frame_assembler_core.sv
// Channel   Dir  Payload             Handshake
// in_       in   sfa_pkg::in_t       in_valid / in_ready
// out_      out  sfa_pkg::out_t      out_valid / out_ready
// cfg_      in   APB, 4-bit paddr    psel / penable, pready always high
//
// One byte per cycle while in_ready is high: each request is decoded in the cycle it is
// accepted and its word, if any, lands in the output register on that edge.
// in_ready is low only while the output register holds a result not yet taken.
// Synchronous active-low reset restores register defaults and clears progress.
// Configuration is read and written at any time; writes take effect next byte.
module spectral_fifo_frame_assembler_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sfa_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration registers
  logic [6:0]  fifo_map_r;
  logic [1:0]  smux_mode_r;
  logic [15:0] high_target_r;
  logic [15:0] low_target_r;

  // Frame and spectrum progress
  logic [3:0]           frame_pos_r, frame_pos_nxt;
  logic [7:0]           low_hold_r, low_hold_nxt;
  logic                 drop_r, drop_nxt;
  sfa_pkg::spec_state_t spec_r, spec_nxt;

  // Output register
  logic          out_valid_r;
  sfa_pkg::out_t out_data_r;

  logic                 in_fire;
  logic                 cfg_wr;
  logic [1:0]           reg_idx;
  logic                 status_len;
  logic [2:0]           word_cnt;
  logic [3:0]           frame_size;
  logic [3:0]           pos;
  logic [3:0]           pos_inc;
  logic                 drop_cur;
  logic                 data_byte_slot;
  logic                 high_byte;
  logic                 take;
  logic [15:0]          word;
  sfa_pkg::spec_state_t unit_nxt;
  sfa_pkg::out_t        unit_res;
  logic                 unit_last;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];

  // Register read
  always_comb begin
    unique case (reg_idx)
      sfa_pkg::REG_FIFO_MAP:    prdata = {25'd0, fifo_map_r};
      sfa_pkg::REG_SMUX_MODE:   prdata = {30'd0, smux_mode_r};
      sfa_pkg::REG_HIGH_TARGET: prdata = {16'd0, high_target_r};
      default:                  prdata = {16'd0, low_target_r};
    endcase
  end

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_map_r    <= sfa_pkg::FIFO_MAP_RST;
      smux_mode_r   <= sfa_pkg::SMUX_MODE_RST;
      high_target_r <= sfa_pkg::HIGH_TARGET_RST;
      low_target_r  <= sfa_pkg::LOW_TARGET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sfa_pkg::REG_FIFO_MAP:    fifo_map_r    <= pwdata[6:0];
        sfa_pkg::REG_SMUX_MODE:   smux_mode_r   <= pwdata[1:0];
        sfa_pkg::REG_HIGH_TARGET: high_target_r <= pwdata[15:0];
        default:                  low_target_r  <= pwdata[15:0];
      endcase
    end
  end

  // Frame geometry from the map
  assign status_len = fifo_map_r[0];
  assign word_cnt   = 3'($countones(fifo_map_r & sfa_pkg::WORD_MAP_MASK));
  assign frame_size = {3'd0, status_len} + {word_cnt, 1'b0};

  // Byte position, restarting the frame if the map shrank under us
  assign pos            = (frame_pos_r >= frame_size) ? 4'd0 : frame_pos_r;
  assign drop_cur       = (frame_pos_r >= frame_size) ? 1'b0 : drop_r;
  assign data_byte_slot = !(status_len && (pos == 4'd0));
  assign high_byte      = pos[0] ^ status_len;
  assign pos_inc        = pos + 4'd1;
  assign word = {in_data.data_byte, low_hold_r};
  assign take = data_byte_slot && high_byte && !drop_cur;

  sfa_peak_unit u_peak (
    .smux_mode   (smux_mode_r),
    .high_target (high_target_r),
    .low_target  (low_target_r),
    .word        (word),
    .cur         (spec_r),
    .nxt         (unit_nxt),
    .result      (unit_res),
    .last        (unit_last)
  );

  // Next-state for one accepted request, data or resync
  always_comb begin
    frame_pos_nxt = frame_pos_r;
    low_hold_nxt  = low_hold_r;
    drop_nxt      = drop_r;
    spec_nxt      = spec_r;
    if (in_data.action == sfa_pkg::ACT_RESYNC) begin
      frame_pos_nxt = 4'd0;
      low_hold_nxt  = 8'd0;
      drop_nxt      = 1'b0;
      spec_nxt      = '0;
    end else if (frame_size != 4'd0) begin
      drop_nxt = drop_cur;
      if (data_byte_slot && !high_byte) begin
        low_hold_nxt = in_data.data_byte;
      end
      if (take) begin
        spec_nxt = unit_nxt;
        if (unit_last) begin
          drop_nxt = 1'b1;
        end
      end
      // End of frame clears the drop flag
      if (pos_inc >= frame_size) begin
        frame_pos_nxt = 4'd0;
        drop_nxt      = 1'b0;
      end else begin
        frame_pos_nxt = pos_inc;
      end
    end
  end

  // Progress state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r <= 4'd0;
      low_hold_r  <= 8'd0;
      drop_r      <= 1'b0;
      spec_r      <= '0;
    end else if (in_fire) begin
      frame_pos_r <= frame_pos_nxt;
      low_hold_r  <= low_hold_nxt;
      drop_r      <= drop_nxt;
      spec_r      <= spec_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && (in_data.action == sfa_pkg::ACT_DATA) &&
                 (frame_size != 4'd0) && take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.action == sfa_pkg::ACT_DATA) &&
        (frame_size != 4'd0) && take) begin
      out_data_r <= unit_res;
    end
  end

endmodule

>>> rtl/sfa_checker.sv
// Port-level checks on the frame assembler
module sfa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input sfa_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input sfa_pkg::out_t out_data
);

  // Held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Peak fields are zero unless the word closes the spectrum
  a_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.spectrum_last |->
      out_data.peak_value == 16'd0 && out_data.peak_channel == 4'd0 &&
      out_data.exposure_verdict == sfa_pkg::VERDICT_HOLD)
    else $error("peak fields set on non-final word");

  // Slot and channel within the sequence
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slot_index <= 5'd17 && out_data.channel_code <= sfa_pkg::CH_FD &&
      out_data.peak_channel <= sfa_pkg::CH_FD)
    else $error("slot or channel out of range");

  // A resync never yields a result
  a_resync_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == sfa_pkg::ACT_RESYNC &&
      (!out_valid || out_ready) |=> !out_valid)
    else $error("result after resync");

  // Empty output register always takes a request
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");

endmodule

bind spectral_fifo_frame_assembler_core sfa_checker u_sfa_checker (.*);

>>> dv/spectrum_word_checker.sv
`timescale 1ns / 1ps

module spectrum_word_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  sfa_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  sfa_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic [31:0]   prdata,
  input  logic          pready,
  output int            fail_count,
  output int            words_waiting,
  output int            words_checked,
  output int            spectra_done
);
  import sfa_pkg::*;

  // Channel tag for each slot of a spectrum, three groups of six
  localparam logic [0:17][3:0] CHAN_SEQ = {
    CH_Z,  CH_Y,  CH_FXL, CH_NIR, CH_VIS, CH_FD,
    CH_F2, CH_F3, CH_F4,  CH_F6,  CH_VIS, CH_FD,
    CH_F1, CH_F7, CH_F8,  CH_F5,  CH_VIS, CH_FD
  };

  // Shadow of the register file
  logic [6:0]  map_q;
  logic [1:0]  mode_q;
  logic [15:0] hi_q;
  logic [15:0] lo_q;

  // Deframing and spectrum progress
  logic [3:0]  byte_pos;
  logic [7:0]  low_hold;
  logic [4:0]  slot;
  logic        dropping;
  logic [15:0] peak;
  logic [3:0]  peak_ch;

  sfa_pkg::out_t expected_words[$];

  initial begin
    fail_count    = 0;
    words_waiting = 0;
    words_checked = 0;
    spectra_done  = 0;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  function automatic string word_text(input sfa_pkg::out_t w);
    return $sformatf("ch=%0d slot=%0d value=%h last=%b peak=%h peak_ch=%0d verdict=%0d",
                     w.channel_code, w.slot_index, w.sample_value, w.spectrum_last,
                     w.peak_value, w.peak_channel, w.exposure_verdict);
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_FIFO_MAP:    return 32'(map_q);
      REG_SMUX_MODE:   return 32'(mode_q);
      REG_HIGH_TARGET: return 32'(hi_q);
      default:         return 32'(lo_q);
    endcase
  endfunction

  task automatic clear_progress();
    byte_pos = '0;
    low_hold = '0;
    slot     = '0;
    dropping = 1'b0;
    peak     = '0;
    peak_ch  = '0;
  endtask

  // Tag one assembled word, fold it into the running peak, queue its result
  task automatic tag_word(input logic [15:0] word);
    int unsigned   len;
    sfa_pkg::out_t res;
    case (mode_q)
      SMUX_SIX:    len = LEN_SIX;
      SMUX_TWELVE: len = LEN_TWELVE;
      default:     len = SEQ_LENGTH;
    endcase
    // spectrum shortened under our feet: start afresh
    if (slot >= len) begin
      slot    = '0;
      peak    = '0;
      peak_ch = '0;
    end
    res = '0;
    res.channel_code = CHAN_SEQ[slot];
    res.slot_index   = slot;
    res.sample_value = word;
    // strict compare, earlier channel wins a tie
    if (word > peak) begin
      peak    = word;
      peak_ch = res.channel_code;
    end
    if (slot + 1 >= len) begin
      res.spectrum_last = 1'b1;
      res.peak_value    = peak;
      res.peak_channel  = peak_ch;
      if (peak > hi_q) res.exposure_verdict = VERDICT_DECREASE;
      else if (peak < lo_q) res.exposure_verdict = VERDICT_INCREASE;
      else res.exposure_verdict = VERDICT_HOLD;
      slot     = '0;
      peak     = '0;
      peak_ch  = '0;
      dropping = 1'b1;
    end else begin
      slot = slot + 5'd1;
    end
    expected_words = {expected_words, res};
  endtask

  // Advance the frame by one accepted request
  task automatic deframe_byte(input sfa_pkg::in_t req);
    int unsigned size;
    int unsigned pos;
    int unsigned q;
    if (req.action == ACT_RESYNC) begin
      clear_progress();
      return;
    end
    size = map_q[0] + 2 * $countones(map_q & WORD_MAP_MASK);
    // empty map: byte ignored
    if (size == 0) return;
    pos = byte_pos;
    if (pos >= size) begin
      pos      = 0;
      dropping = 1'b0;
    end
    if (!(map_q[0] && pos == 0)) begin
      q = pos - map_q[0];
      if (q % 2 == 0) low_hold = req.data_byte;
      else if (!dropping) tag_word({req.data_byte, low_hold});
    end
    pos++;
    if (pos >= size) begin
      pos      = 0;
      dropping = 1'b0;
    end
    byte_pos = pos[3:0];
  endtask

  task automatic check_word(input sfa_pkg::out_t got);
    sfa_pkg::out_t want;
    if (expected_words.size() == 0) begin
      note_failure({"unexpected result ", word_text(got)});
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (want.spectrum_last) spectra_done++;
    if (got.channel_code !== want.channel_code || got.slot_index !== want.slot_index ||
        got.sample_value !== want.sample_value || got.spectrum_last !== want.spectrum_last ||
        got.peak_value !== want.peak_value || got.peak_channel !== want.peak_channel ||
        got.exposure_verdict !== want.exposure_verdict) begin
      note_failure({"expected ", word_text(want), " got ", word_text(got)});
    end
  endtask

  // Results first, so a stray word is never matched by a request of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      map_q  = FIFO_MAP_RST;
      mode_q = SMUX_MODE_RST;
      hi_q   = HIGH_TARGET_RST;
      lo_q   = LOW_TARGET_RST;
      clear_progress();
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_FIFO_MAP:    map_q  = pwdata[6:0];
            REG_SMUX_MODE:   mode_q = pwdata[1:0];
            REG_HIGH_TARGET: hi_q   = pwdata[15:0];
            default:         lo_q   = pwdata[15:0];
          endcase
        end else if (prdata !== reg_value(paddr[3:2])) begin
          note_failure($sformatf("register %0d read: expected %h got %h",
                                 paddr[3:2], reg_value(paddr[3:2]), prdata));
        end
      end
      if (in_valid && in_ready) deframe_byte(in_data);
    end
    words_waiting = expected_words.size();
  end

endmodule

>>> dv/tb_spectral_fifo_frame_assembler_core.sv
`timescale 1ns / 1ps

module tb_spectral_fifo_frame_assembler_core;
  import sfa_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned REQS_PER_PHASE  = 125;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 3;
  localparam int unsigned IDLE_PERCENT    = 32;
  localparam int unsigned RESYNC_PERCENT  = 3;

  localparam logic [1:0] SMUX_EIGHTEEN = 2'd2;
  localparam logic [1:0] SMUX_UNUSED   = 2'd3;

  // Target picks for a random setting
  localparam int unsigned TGT_WIDE     = 0;
  localparam int unsigned TGT_INVERTED = 1;
  localparam int unsigned TGT_RANDOM   = 2;
  localparam int unsigned TGT_LOW      = 3;

  // Two frames of words, one word tying the peak, then a spectrum end mid-frame
  localparam logic [0:15][7:0] DROP_FRAME_BYTES = {
    8'h32, 8'h00, 8'hc8, 8'h00, 8'hc8, 8'h00, 8'h07, 8'h00,
    8'h64, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff
  };

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  sfa_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  sfa_pkg::out_t out_data;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [3:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  int          fail_count;
  int          words_waiting;
  int          words_checked;
  int          spectra_done;
  int unsigned reqs_sent;
  int unsigned settings_used;

  bit gaps_on;
  bit stall_on;
  bit hold_start;
  bit hold_off;

  spectral_fifo_frame_assembler_core DUT (.*);

  spectrum_word_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or held off entirely
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (stall_on) out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      else out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off so the output backs up and in_ready drops
  initial begin
    hold_off = 1'b0;
    wait (hold_start);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", words_waiting);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_req(input logic act, input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data.action    <= act;
    in_data.data_byte <= b;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
  endtask

  // Drop valid, let every expected word drain, then allow for the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_regs();
    for (int i = REG_FIFO_MAP; i <= REG_LOW_TARGET; i++) reg_access(2'(i), 1'b0, '0);
  endtask

  task automatic set_regs(input logic [6:0] map, input logic [1:0] mode,
                          input logic [15:0] hi, input logic [15:0] lo);
    wait_idle();
    reg_access(REG_FIFO_MAP, 1'b1, 32'(map));
    reg_access(REG_SMUX_MODE, 1'b1, 32'(mode));
    reg_access(REG_HIGH_TARGET, 1'b1, 32'(hi));
    reg_access(REG_LOW_TARGET, 1'b1, 32'(lo));
    read_regs();
    settings_used++;
  endtask

  // Flags change just after a rising edge, away from the falling-edge drivers
  task automatic set_idling(input bit gaps, input bit stalls);
    @(posedge clk);
    gaps_on  = gaps;
    stall_on = stalls;
  endtask

  task automatic pick_targets(input int unsigned kind, output logic [15:0] hi,
                              output logic [15:0] lo);
    case (kind)
      TGT_WIDE: begin
        hi = 16'hffff;
        lo = 16'h0000;
      end
      TGT_INVERTED: begin
        hi = 16'h0000;
        lo = 16'hffff;
      end
      TGT_RANDOM: begin
        hi = 16'($urandom_range(16'hffff));
        lo = 16'($urandom_range(16'hffff));
      end
      default: begin
        hi = 16'($urandom_range(16'h0f0f));
        lo = 16'($urandom_range(16'h0f0f));
      end
    endcase
  endtask

  function automatic logic [7:0] rand_byte(input int unsigned ceiling);
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(ceiling));
    endcase
  endfunction

  initial begin
    logic [6:0]  map;
    logic [1:0]  mode;
    logic [15:0] hi;
    logic [15:0] lo;
    int unsigned ceiling;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    reqs_sent     = 0;
    settings_used = 1;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    hold_start    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    read_regs();

    // Default setting: status byte, extreme words, resync mid-frame
    send_req(ACT_RESYNC, 8'h3c);
    send_req(ACT_DATA, 8'h5a);
    send_req(ACT_DATA, 8'hff);
    send_req(ACT_DATA, 8'hff);
    send_req(ACT_DATA, 8'h00);
    send_req(ACT_DATA, 8'h00);
    send_req(ACT_DATA, 8'h80);
    send_req(ACT_RESYNC, 8'hc3);

    // Empty map ignores bytes; status-only map gives no words
    set_regs(7'h00, SMUX_EIGHTEEN, HIGH_TARGET_RST, LOW_TARGET_RST);
    send_req(ACT_DATA, 8'hff);
    send_req(ACT_DATA, 8'h00);
    set_regs(7'h01, SMUX_EIGHTEEN, HIGH_TARGET_RST, LOW_TARGET_RST);
    send_req(ACT_DATA, 8'hff);
    send_req(ACT_DATA, 8'h00);

    // Six-slot spectrum over four-word frames: tie, decrease, drop of the tail
    set_regs(7'h1e, SMUX_SIX, 16'd100, 16'd50);
    for (int i = 0; i < 16; i++) send_req(ACT_DATA, DROP_FRAME_BYTES[i]);

    // Random phases; setting changes leave frames and spectra part done
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_regs(FIFO_MAP_RST, SMUX_MODE_RST, HIGH_TARGET_RST, LOW_TARGET_RST);
        1: set_regs(7'h7e, SMUX_TWELVE, 16'h0000, 16'hffff);
        2: begin
          pick_targets(TGT_RANDOM, hi, lo);
          set_regs(7'h7f, SMUX_UNUSED, hi, lo);
        end
        3: begin
          pick_targets(TGT_LOW, hi, lo);
          set_regs(7'h02, SMUX_SIX, hi, lo);
        end
        default: begin
          do map = 7'($urandom_range(127)); while ((map & WORD_MAP_MASK) == 0);
          mode = 2'($urandom_range(3));
          pick_targets($urandom_range(TGT_LOW), hi, lo);
          set_regs(map, mode, hi, lo);
        end
      endcase
      // one stretch with neither side idling
      set_idling(ph != 1, ph != 1);
      if (ph == 2) hold_start = 1'b1;
      ceiling = (ph == 3 || $urandom_range(1)) ? 15 : 255;
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        send_req(($urandom_range(99) < RESYNC_PERCENT) ? ACT_RESYNC : ACT_DATA,
                 rand_byte(ceiling));
      end
    end

    wait_idle();
    $display("Sent %0d requests over %0d register settings, with a %0d-cycle receiver hold-off.",
             reqs_sent, settings_used, HOLD_OFF_CYCLES);
    $display("Checked %0d words, %0d of which closed a spectrum.", words_checked, spectra_done);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
